### rtl/core/atrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_pkg: shared types and constants for the AT response parser
// Parser states, status codes, character codes and the per-request structs.
// ----------------------------------------------------------------------------
package atrp_pkg;

    // Hard caps on the programmable limits
    localparam int unsigned MAX_LINES      = 1024;
    localparam int unsigned MAX_LINE_BYTES = 1024;

    localparam int unsigned CNT_W    = 11;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 1'b1;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd1000;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_ACCEPT     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SYNTAX     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY   = 2'd3;

    // Characters
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'd126;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;

    typedef enum logic [3:0] {
        ST_CR0,
        ST_LF0,
        ST_FIRST,
        ST_TXT0,
        ST_TXT,
        ST_TXT_LF,
        ST_NEXT,
        ST_BLANK_LF,
        ST_RESULT,
        ST_OK_K,
        ST_ER_R1,
        ST_ER_R2,
        ST_ER_O,
        ST_ER_R3,
        ST_FIN_CR,
        ST_FIN_LF
    } parse_state_t;

    // Parser context carried from one byte to the next
    typedef struct packed {
        parse_state_t     state;
        logic [CNT_W-1:0] line_cnt;
        logic [CNT_W-1:0] line_length;
        logic             ok_flag;
        logic             line_limit_hit;
    } ctx_t;

    // One result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                store_valid;
        logic [SLOT_W-1:0]   store_line;
        logic [CNT_W-1:0]    store_pos;
        logic [BYTE_W-1:0]   store_byte;
        logic                response_done;
        logic                response_ok;
        logic [CNT_W-1:0]    lines_in_response;
    } result_t;

endpackage

### rtl/core/atrp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_if: valid/ready channels of the AT response parser
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
interface atrp_rx_if;
    logic                        valid;
    logic                        ready;
    logic [atrp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atrp_res_if;
    logic                          valid;
    logic                          ready;
    logic [atrp_pkg::STATUS_W-1:0] status;
    logic                          store_valid;
    logic [atrp_pkg::SLOT_W-1:0]   store_line;
    logic [atrp_pkg::CNT_W-1:0]    store_pos;
    logic [atrp_pkg::BYTE_W-1:0]   store_byte;
    logic                          response_done;
    logic                          response_ok;
    logic [atrp_pkg::CNT_W-1:0]    lines_in_response;

    modport source (output valid, output status, output store_valid, output store_line,
                    output store_pos, output store_byte, output response_done,
                    output response_ok, output lines_in_response, input ready);
    modport sink   (input valid, input status, input store_valid, input store_line,
                    input store_pos, input store_byte, input response_done,
                    input response_ok, input lines_in_response, output ready);
endinterface

interface atrp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [atrp_pkg::CFG_IDX_W-1:0] reg_index;
    logic [atrp_pkg::CNT_W-1:0]     wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/core/atrp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_step: per-byte parser logic
// Takes the current context and one byte, gives the next context and result.
// ----------------------------------------------------------------------------
module atrp_step
(
    input  atrp_pkg::ctx_t                   ctx,
    input  logic [atrp_pkg::BYTE_W-1:0]      rx_byte,
    input  logic [atrp_pkg::CNT_W-1:0]       line_limit,
    input  logic [atrp_pkg::CNT_W-1:0]       length_limit,
    output atrp_pkg::ctx_t                   ctx_next,
    output atrp_pkg::result_t                result
);

    logic bad;
    logic printable;
    logic lines_full;
    logic length_full;
    atrp_pkg::parse_state_t state_next;

    assign printable = (rx_byte >= atrp_pkg::CH_SPACE) && (rx_byte <= atrp_pkg::CH_TILDE);

    // effective limit is min(register, cap)
    assign lines_full  = (ctx.line_cnt >= line_limit)
                      || ({21'd0, ctx.line_cnt} >= 32'(atrp_pkg::MAX_LINES));
    assign length_full = (ctx.line_length >= length_limit)
                      || ({21'd0, ctx.line_length} >= 32'(atrp_pkg::MAX_LINE_BYTES));

    // byte legal in the current state?
    always_comb
    begin
        unique case (ctx.state)
            atrp_pkg::ST_CR0, atrp_pkg::ST_FIN_CR:
                bad = (rx_byte != atrp_pkg::CH_CR);
            atrp_pkg::ST_LF0, atrp_pkg::ST_TXT_LF, atrp_pkg::ST_BLANK_LF, atrp_pkg::ST_FIN_LF:
                bad = (rx_byte != atrp_pkg::CH_LF);
            atrp_pkg::ST_FIRST:
                bad = !((rx_byte == atrp_pkg::CH_PLUS) || (rx_byte == atrp_pkg::CH_O)
                        || (rx_byte == atrp_pkg::CH_E));
            atrp_pkg::ST_TXT0:
                bad = !printable;
            atrp_pkg::ST_TXT:
                bad = !(printable || (rx_byte == atrp_pkg::CH_CR));
            atrp_pkg::ST_NEXT:
                bad = !((rx_byte == atrp_pkg::CH_PLUS) || (rx_byte == atrp_pkg::CH_CR));
            atrp_pkg::ST_RESULT:
                bad = !((rx_byte == atrp_pkg::CH_O) || (rx_byte == atrp_pkg::CH_E));
            atrp_pkg::ST_OK_K:
                bad = (rx_byte != atrp_pkg::CH_K);
            atrp_pkg::ST_ER_R1, atrp_pkg::ST_ER_R2, atrp_pkg::ST_ER_R3:
                bad = (rx_byte != atrp_pkg::CH_R);
            atrp_pkg::ST_ER_O:
                bad = (rx_byte != atrp_pkg::CH_O);
        endcase
    end

    // next state
    always_comb
    begin
        state_next = ctx.state;
        if (bad)
        begin
            // bad CR restarts at the LF of a new frame
            state_next = (rx_byte == atrp_pkg::CH_CR) ? atrp_pkg::ST_LF0 : atrp_pkg::ST_CR0;
        end
        else
        begin
            unique case (ctx.state)
                atrp_pkg::ST_CR0:      state_next = atrp_pkg::ST_LF0;
                atrp_pkg::ST_LF0:      state_next = atrp_pkg::ST_FIRST;
                atrp_pkg::ST_FIRST, atrp_pkg::ST_RESULT:
                begin
                    priority if (rx_byte == atrp_pkg::CH_PLUS) state_next = atrp_pkg::ST_TXT0;
                    else if (rx_byte == atrp_pkg::CH_O)        state_next = atrp_pkg::ST_OK_K;
                    else                                       state_next = atrp_pkg::ST_ER_R1;
                end
                atrp_pkg::ST_TXT0, atrp_pkg::ST_TXT:
                    state_next = printable ? atrp_pkg::ST_TXT : atrp_pkg::ST_TXT_LF;
                atrp_pkg::ST_TXT_LF:   state_next = atrp_pkg::ST_NEXT;
                atrp_pkg::ST_NEXT:
                    state_next = (rx_byte == atrp_pkg::CH_PLUS) ? atrp_pkg::ST_TXT0
                                                                : atrp_pkg::ST_BLANK_LF;
                atrp_pkg::ST_BLANK_LF: state_next = atrp_pkg::ST_RESULT;
                atrp_pkg::ST_OK_K:     state_next = atrp_pkg::ST_FIN_CR;
                atrp_pkg::ST_ER_R1:    state_next = atrp_pkg::ST_ER_R2;
                atrp_pkg::ST_ER_R2:    state_next = atrp_pkg::ST_ER_O;
                atrp_pkg::ST_ER_O:     state_next = atrp_pkg::ST_ER_R3;
                atrp_pkg::ST_ER_R3:    state_next = atrp_pkg::ST_FIN_CR;
                atrp_pkg::ST_FIN_CR:   state_next = atrp_pkg::ST_FIN_LF;
                atrp_pkg::ST_FIN_LF:   state_next = atrp_pkg::ST_CR0;
            endcase
        end
    end

    // counters, flags and result fields
    always_comb
    begin
        ctx_next       = ctx;
        ctx_next.state = state_next;
        result         = '0;
        result.status  = atrp_pkg::STATUS_ACCEPT;

        if (bad)
        begin
            result.status = atrp_pkg::STATUS_SYNTAX;
            if (rx_byte == atrp_pkg::CH_CR)
            begin
                ctx_next.line_cnt       = '0;
                ctx_next.line_length    = '0;
                ctx_next.line_limit_hit = 1'b0;
            end
        end
        else
        begin
            unique case (ctx.state)
                atrp_pkg::ST_CR0:
                begin
                    ctx_next.line_cnt       = '0;
                    ctx_next.line_length    = '0;
                    ctx_next.line_limit_hit = 1'b0;
                end
                atrp_pkg::ST_FIRST, atrp_pkg::ST_NEXT:
                begin
                    if (rx_byte == atrp_pkg::CH_PLUS)
                    begin
                        if (lines_full)
                        begin
                            ctx_next.line_limit_hit = 1'b1;
                            result.status           = atrp_pkg::STATUS_TOO_MANY;
                        end
                        else
                        begin
                            ctx_next.line_cnt = ctx.line_cnt + 11'd1;
                        end
                    end
                end
                atrp_pkg::ST_TXT0, atrp_pkg::ST_TXT:
                begin
                    if (printable)
                    begin
                        priority if (ctx.line_limit_hit)
                            result.status = atrp_pkg::STATUS_TOO_MANY;
                        else if (length_full)
                            result.status = atrp_pkg::STATUS_TOO_LONG;
                        else
                        begin
                            result.store_valid   = 1'b1;
                            result.store_line    = ctx.line_cnt[atrp_pkg::SLOT_W-1:0] - 10'd1;
                            result.store_pos     = ctx.line_length;
                            result.store_byte    = rx_byte;
                            ctx_next.line_length = ctx.line_length + 11'd1;
                        end
                    end
                    else
                    begin
                        // end of line: terminator at current position
                        if (ctx.line_limit_hit)
                            result.status = atrp_pkg::STATUS_TOO_MANY;
                        else
                        begin
                            result.store_valid = 1'b1;
                            result.store_line  = ctx.line_cnt[atrp_pkg::SLOT_W-1:0] - 10'd1;
                            result.store_pos   = ctx.line_length;
                            result.store_byte  = atrp_pkg::CH_NUL;
                        end
                        ctx_next.line_length = '0;
                    end
                end
                atrp_pkg::ST_OK_K:   ctx_next.ok_flag = 1'b1;
                atrp_pkg::ST_ER_R3:  ctx_next.ok_flag = 1'b0;
                atrp_pkg::ST_FIN_LF:
                begin
                    result.response_done = 1'b1;
                    result.response_ok   = ctx.ok_flag;
                end
                atrp_pkg::ST_LF0, atrp_pkg::ST_TXT_LF, atrp_pkg::ST_BLANK_LF,
                atrp_pkg::ST_RESULT, atrp_pkg::ST_ER_R1, atrp_pkg::ST_ER_R2,
                atrp_pkg::ST_ER_O, atrp_pkg::ST_FIN_CR:
                begin
                    ctx_next.state = state_next;
                end
            endcase
        end

        result.lines_in_response = ctx_next.line_cnt;
    end

endmodule

### rtl/core/at_response_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_parser: modem AT response frame checker
// Checks CR LF framing, '+' lines, OK / ERROR and emits line-store writes.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                                   | Request
//  --------+-----+-------------------------------------------+--------------------
//  rx      | in  | rx_byte                                   | one response byte
//  res     | out | status, store_*, response_done/_ok, lines | one result per byte
//  cfg     | in  | reg_index, wr_data                        | one register write
//
//  One byte per cycle sustained while res.ready is high. An input register
//  holds the byte; the parser logic runs between it and the result register.
//  The parser context updates as a byte moves into the result register, so
//  consecutive bytes chain through without bubbles.
//  A stalled res.ready holds the result; rx.ready drops only once the input
//  register is also full. cfg is always ready; write it only while idle.
//  Reset: parser waits for the first CR, counts clear, both limits are 1000.
//
module at_response_parser
(
    input  logic            clk,
    input  logic            rst_n,
    atrp_rx_if.sink         rx,
    atrp_res_if.source      res,
    atrp_cfg_if.sink        cfg
);

    // configuration registers
    logic [atrp_pkg::CNT_W-1:0] line_limit_reg;
    logic [atrp_pkg::CNT_W-1:0] length_limit_reg;

    // input stage
    logic                        in_valid_reg;
    logic [atrp_pkg::BYTE_W-1:0] in_byte_reg;

    // parser context and result stage
    atrp_pkg::ctx_t    ctx_reg;
    atrp_pkg::ctx_t    ctx_next;
    atrp_pkg::result_t res_next;
    atrp_pkg::result_t res_reg;
    logic              out_valid_reg;

    logic advance;

    // pipeline moves when the result slot is free or being taken
    assign advance  = !out_valid_reg || res.ready;
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg   <= atrp_pkg::LIMIT_RESET;
            length_limit_reg <= atrp_pkg::LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                atrp_pkg::CFG_LINE_LIMIT:   line_limit_reg   <= cfg.wr_data;
                atrp_pkg::CFG_LENGTH_LIMIT: length_limit_reg <= cfg.wr_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    atrp_step u_step
    (
        .ctx          (ctx_reg),
        .rx_byte      (in_byte_reg),
        .line_limit   (line_limit_reg),
        .length_limit (length_limit_reg),
        .ctx_next     (ctx_next),
        .result       (res_next)
    );

    // context commits only when the byte's result is registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.state          <= atrp_pkg::ST_CR0;
            ctx_reg.line_cnt       <= '0;
            ctx_reg.line_length    <= '0;
            ctx_reg.ok_flag        <= 1'b0;
            ctx_reg.line_limit_hit <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                ctx_reg <= ctx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.status            = res_reg.status;
    assign res.store_valid       = res_reg.store_valid;
    assign res.store_line        = res_reg.store_line;
    assign res.store_pos         = res_reg.store_pos;
    assign res.store_byte        = res_reg.store_byte;
    assign res.response_done     = res_reg.response_done;
    assign res.response_ok       = res_reg.response_ok;
    assign res.lines_in_response = res_reg.lines_in_response;

endmodule

### rtl/core/atrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_checker: port-level checks for the AT response parser
// Result consistency and output hold under stall; bound to the top level.
// ----------------------------------------------------------------------------
module atrp_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [atrp_pkg::STATUS_W-1:0] status,
    input logic                          store_valid,
    input logic [atrp_pkg::CNT_W-1:0]    store_pos,
    input logic                          response_done,
    input logic                          response_ok,
    input logic [atrp_pkg::CNT_W-1:0]    lines_in_response
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(store_pos)
                                    && $stable(lines_in_response))
        else $error("result changed under stall");

    // completion byte is a clean LF, never a store
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && response_done |-> status == atrp_pkg::STATUS_ACCEPT && !store_valid)
        else $error("done with store or bad status");

    // store only on accepted bytes of a counted line
    a_store_line: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && store_valid |-> status == atrp_pkg::STATUS_ACCEPT
                                     && lines_in_response != '0)
        else $error("store without a counted line");

    a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && response_ok |-> response_done)
        else $error("ok without done");

endmodule

bind at_response_parser atrp_checker u_atrp_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .status            (res.status),
    .store_valid       (res.store_valid),
    .store_pos         (res.store_pos),
    .response_done     (res.response_done),
    .response_ok       (res.response_ok),
    .lines_in_response (res.lines_in_response)
);

### sim/at_response_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_parser_test: self-checking bench for the AT response parser
// Feeds framed modem responses (clean, corrupted, cut short and raw noise)
// through the byte channel under several line and length limits. A
// scoreboard predicts the status, store write, done flag and line count of
// every byte, and checks each result in order.
// ----------------------------------------------------------------------------
module at_response_parser_test;

    typedef logic [atrp_pkg::BYTE_W-1:0] octet_t;
    typedef logic [atrp_pkg::CNT_W-1:0]  count_t;
    typedef logic [atrp_pkg::SLOT_W-1:0] slot_t;

    // Receiver ready patterns, picked per stretch of cycles
    typedef enum int unsigned {
        SINK_OPEN,
        SINK_COIN,
        SINK_EVERY4,
        SINK_MOSTLY
    } sink_mode_t;

    localparam octet_t      CH_DEL        = 8'd127;
    localparam int unsigned PHASE_BYTES   = 95;   // random bytes per limit setting
    localparam int unsigned SETTLE_CYCLES = 8;    // settle time once all results are back
    localparam int unsigned QUIET_LIMIT   = 2000; // cycles without any request
    localparam int unsigned N_SETTINGS    = 6;
    localparam int unsigned REPORT_CAP    = 50;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks parser context and limits, queues one expected
    // result per accepted byte and compares results against it in order.
    // ------------------------------------------------------------------------
    class parse_scoreboard;
        atrp_pkg::result_t      pending[$];
        atrp_pkg::parse_state_t state;
        count_t                 nlines;
        count_t                 nchars;
        logic                   ok_seen;
        logic                   lines_full;
        int unsigned            line_cap;
        int unsigned            char_cap;
        int unsigned            errors;
        int unsigned            checked;
        int unsigned            ok_frames;
        int unsigned            error_frames;
        int unsigned            syntax_hits;
        int unsigned            long_drops;
        int unsigned            many_drops;

        function new();
            state      = atrp_pkg::ST_CR0;
            nlines     = '0;
            nchars     = '0;
            ok_seen    = 1'b0;
            lines_full = 1'b0;
            line_cap   = atrp_pkg::LIMIT_RESET;
            char_cap   = atrp_pkg::LIMIT_RESET;
        endfunction

        function void set_limit(logic [atrp_pkg::CFG_IDX_W-1:0] idx, count_t value);
            if (idx == atrp_pkg::CFG_LINE_LIMIT)
                line_cap = (value < atrp_pkg::MAX_LINES) ? value : atrp_pkg::MAX_LINES;
            else
                char_cap = (value < atrp_pkg::MAX_LINE_BYTES) ? value
                                                              : atrp_pkg::MAX_LINE_BYTES;
        endfunction

        function void clear_counts();
            nlines     = '0;
            nchars     = '0;
            lines_full = 1'b0;
        endfunction

        // Bad byte: back to the start, or straight to the LF wait on a CR
        function logic [atrp_pkg::STATUS_W-1:0] restart(octet_t b);
            if (b == atrp_pkg::CH_CR)
            begin
                state = atrp_pkg::ST_LF0;
                clear_counts();
            end
            else
                state = atrp_pkg::ST_CR0;
            return atrp_pkg::STATUS_SYNTAX;
        endfunction

        function logic [atrp_pkg::STATUS_W-1:0] open_line();
            state = atrp_pkg::ST_TXT0;
            if (nlines >= line_cap)
            begin
                lines_full = 1'b1;
                return atrp_pkg::STATUS_TOO_MANY;
            end
            nlines++;
            return atrp_pkg::STATUS_ACCEPT;
        endfunction

        function void note_byte(octet_t b);
            atrp_pkg::result_t r;
            logic              text;
            r    = '0;
            text = (b >= atrp_pkg::CH_SPACE) && (b <= atrp_pkg::CH_TILDE);
            case (state)
                atrp_pkg::ST_CR0:
                    if (b == atrp_pkg::CH_CR)
                    begin
                        state = atrp_pkg::ST_LF0;
                        clear_counts();
                    end
                    else
                        r.status = restart(b);
                atrp_pkg::ST_LF0:
                    if (b == atrp_pkg::CH_LF) state = atrp_pkg::ST_FIRST;
                    else r.status = restart(b);
                atrp_pkg::ST_FIRST:
                    if (b == atrp_pkg::CH_PLUS) r.status = open_line();
                    else if (b == atrp_pkg::CH_O) state = atrp_pkg::ST_OK_K;
                    else if (b == atrp_pkg::CH_E) state = atrp_pkg::ST_ER_R1;
                    else r.status = restart(b);
                atrp_pkg::ST_TXT0, atrp_pkg::ST_TXT:
                    if (text)
                    begin
                        state = atrp_pkg::ST_TXT;
                        if (lines_full)
                            r.status = atrp_pkg::STATUS_TOO_MANY;
                        else if (nchars >= char_cap)
                            r.status = atrp_pkg::STATUS_TOO_LONG;
                        else
                        begin
                            r.store_valid = 1'b1;
                            r.store_line  = slot_t'(nlines - 1'b1);
                            r.store_pos   = nchars;
                            r.store_byte  = b;
                            nchars++;
                        end
                    end
                    else if (b == atrp_pkg::CH_CR && state == atrp_pkg::ST_TXT)
                    begin
                        // terminator lands right after the last stored char
                        state = atrp_pkg::ST_TXT_LF;
                        if (lines_full)
                            r.status = atrp_pkg::STATUS_TOO_MANY;
                        else
                        begin
                            r.store_valid = 1'b1;
                            r.store_line  = slot_t'(nlines - 1'b1);
                            r.store_pos   = nchars;
                            r.store_byte  = atrp_pkg::CH_NUL;
                        end
                        nchars = '0;
                    end
                    else
                        r.status = restart(b);
                atrp_pkg::ST_TXT_LF:
                    if (b == atrp_pkg::CH_LF) state = atrp_pkg::ST_NEXT;
                    else r.status = restart(b);
                atrp_pkg::ST_NEXT:
                    if (b == atrp_pkg::CH_PLUS) r.status = open_line();
                    else if (b == atrp_pkg::CH_CR) state = atrp_pkg::ST_BLANK_LF;
                    else r.status = restart(b);
                atrp_pkg::ST_BLANK_LF:
                    if (b == atrp_pkg::CH_LF) state = atrp_pkg::ST_RESULT;
                    else r.status = restart(b);
                atrp_pkg::ST_RESULT:
                    if (b == atrp_pkg::CH_O) state = atrp_pkg::ST_OK_K;
                    else if (b == atrp_pkg::CH_E) state = atrp_pkg::ST_ER_R1;
                    else r.status = restart(b);
                atrp_pkg::ST_OK_K:
                    if (b == atrp_pkg::CH_K)
                    begin
                        state   = atrp_pkg::ST_FIN_CR;
                        ok_seen = 1'b1;
                    end
                    else
                        r.status = restart(b);
                atrp_pkg::ST_ER_R1:
                    if (b == atrp_pkg::CH_R) state = atrp_pkg::ST_ER_R2;
                    else r.status = restart(b);
                atrp_pkg::ST_ER_R2:
                    if (b == atrp_pkg::CH_R) state = atrp_pkg::ST_ER_O;
                    else r.status = restart(b);
                atrp_pkg::ST_ER_O:
                    if (b == atrp_pkg::CH_O) state = atrp_pkg::ST_ER_R3;
                    else r.status = restart(b);
                atrp_pkg::ST_ER_R3:
                    if (b == atrp_pkg::CH_R)
                    begin
                        state   = atrp_pkg::ST_FIN_CR;
                        ok_seen = 1'b0;
                    end
                    else
                        r.status = restart(b);
                atrp_pkg::ST_FIN_CR:
                    if (b == atrp_pkg::CH_CR) state = atrp_pkg::ST_FIN_LF;
                    else r.status = restart(b);
                atrp_pkg::ST_FIN_LF:
                    if (b == atrp_pkg::CH_LF)
                    begin
                        state           = atrp_pkg::ST_CR0;
                        r.response_done = 1'b1;
                        r.response_ok   = ok_seen;
                    end
                    else
                        r.status = restart(b);
                default:
                    r.status = restart(b);
            endcase
            r.lines_in_response = nlines;
            pending.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_CAP)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check(atrp_pkg::result_t got);
            atrp_pkg::result_t want;
            string             diff;
            if (pending.size() == 0)
            begin
                report($sformatf("result with no byte outstanding: %p", got));
                return;
            end
            want = pending.pop_front();
            diff = "";
            if (got.status !== want.status)                       diff = {diff, " status"};
            if (got.store_valid !== want.store_valid)             diff = {diff, " store_valid"};
            if (got.store_line !== want.store_line)               diff = {diff, " store_line"};
            if (got.store_pos !== want.store_pos)                 diff = {diff, " store_pos"};
            if (got.store_byte !== want.store_byte)               diff = {diff, " store_byte"};
            if (got.response_done !== want.response_done)         diff = {diff, " response_done"};
            if (got.response_ok !== want.response_ok)             diff = {diff, " response_ok"};
            if (got.lines_in_response !== want.lines_in_response) diff = {diff, " lines"};
            if (diff.len() != 0)
                report($sformatf("result %0d:%s got %p want %p", checked, diff, got, want));
            checked++;
            if (want.response_done && want.response_ok)  ok_frames++;
            if (want.response_done && !want.response_ok) error_frames++;
            if (want.status == atrp_pkg::STATUS_SYNTAX)   syntax_hits++;
            if (want.status == atrp_pkg::STATUS_TOO_LONG) long_drops++;
            if (want.status == atrp_pkg::STATUS_TOO_MANY) many_drops++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels, block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    atrp_rx_if  rx();
    atrp_res_if res();
    atrp_cfg_if cfg();

    at_response_parser i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    parse_scoreboard sb;
    octet_t          frame[$];       // bytes of the response being sent
    int unsigned     burst_left = 0; // requests left in the current sender burst
    int unsigned     bytes_sent = 0;

    // ------------------------------------------------------------------------
    // Receiver: ready follows one of a few patterns, each held for a random
    // stretch, so stalls land on every phase of the parser. One mode never
    // stalls at all.
    // ------------------------------------------------------------------------
    initial
    begin : sink_ready
        sink_mode_t  mode;
        int unsigned left;
        int unsigned tick;
        mode      = SINK_OPEN;
        left      = 0;
        tick      = 0;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                left = $urandom_range(16, 80);
            end
            left--;
            tick++;
            case (mode)
                SINK_OPEN:   res.ready = 1'b1;
                SINK_COIN:   res.ready = $urandom_range(0, 1);
                SINK_EVERY4: res.ready = (tick % 4 == 0);
                default:     res.ready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Register writes and
    // accepted bytes are noted before a result is checked, so the order of
    // the scoreboard calls never depends on scheduling. The watchdog ends the
    // run when no request of any kind completes for too long.
    // ------------------------------------------------------------------------
    int unsigned quiet = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                sb.set_limit(cfg.reg_index, cfg.wr_data);
            if (rx.valid && rx.ready)
                sb.note_byte(rx.rx_byte);
            if (res.valid && res.ready)
                sb.check({res.status, res.store_valid, res.store_line, res.store_pos,
                          res.store_byte, res.response_done, res.response_ok,
                          res.lines_in_response});
            if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no request for %0d cycles, %0d results outstanding",
                         quiet, sb.pending.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. All of them are entered and left just after a falling
    // edge; inputs only ever change there.
    // ------------------------------------------------------------------------

    // One byte request. The sender works in bursts; between bursts it drops
    // valid for a random gap, and now and then runs straight on with no gap.
    task automatic send_byte(octet_t b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                rx.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        rx.valid   = 1'b1;
        rx.rx_byte = b;
        do @(posedge clk); while (!rx.ready);
        @(negedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[k])
            send_byte(frame[k]);
    endtask

    // Stop sending until every expected result is back, then let the block
    // settle. Register writes only follow one of these.
    task automatic drain();
        rx.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [atrp_pkg::CFG_IDX_W-1:0] idx, count_t value);
        cfg.valid     = 1'b1;
        cfg.reg_index = idx;
        cfg.wr_data   = value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic octet_t text_char();
        return octet_t'($urandom_range(atrp_pkg::CH_SPACE, atrp_pkg::CH_TILDE));
    endfunction

    // Random traffic under the current limits. Most responses are clean so
    // the parser gets deep into '+' lines and the limit checks; the rest are
    // corrupted, cut short, or plain noise.
    task automatic run_phase(int unsigned quota);
        octet_t      specials[9];
        int unsigned sent;
        int unsigned n_lines;
        int unsigned n_chars;
        int unsigned line_room;
        int unsigned char_room;
        int unsigned kind;
        int unsigned at;
        specials = '{atrp_pkg::CH_CR, atrp_pkg::CH_LF, atrp_pkg::CH_PLUS, atrp_pkg::CH_O,
                     atrp_pkg::CH_E, atrp_pkg::CH_K, atrp_pkg::CH_R, CH_DEL,
                     atrp_pkg::CH_NUL};
        sent     = 0;
        while (sent < quota)
        begin
            // Keep counts a little past the limit so drops show up, but small
            line_room = (sb.line_cap < 3) ? sb.line_cap : 3;
            char_room = (sb.char_cap < 8) ? sb.char_cap : 8;
            frame = '{atrp_pkg::CH_CR, atrp_pkg::CH_LF};
            n_lines = $urandom_range(0, line_room + 1);
            repeat (n_lines)
            begin
                frame.push_back(atrp_pkg::CH_PLUS);
                n_chars = $urandom_range(1, char_room + 2);
                repeat (n_chars) frame.push_back(text_char());
                frame.push_back(atrp_pkg::CH_CR);
                frame.push_back(atrp_pkg::CH_LF);
            end
            if (n_lines != 0)
                frame = {frame, atrp_pkg::CH_CR, atrp_pkg::CH_LF};  // blank line
            if ($urandom_range(0, 1))
                frame = {frame, atrp_pkg::CH_O, atrp_pkg::CH_K};
            else
                frame = {frame, atrp_pkg::CH_E, atrp_pkg::CH_R, atrp_pkg::CH_R,
                         atrp_pkg::CH_O, atrp_pkg::CH_R};
            frame = {frame, atrp_pkg::CH_CR, atrp_pkg::CH_LF};

            kind = $urandom_range(0, 9);
            at   = $urandom_range(0, frame.size() - 1);
            if (kind == 6)
                frame[at] = octet_t'($urandom_range(0, 255));
            else if (kind == 7)
                while (frame.size() > at) void'(frame.pop_back());
            else if (kind == 8)
                frame[at] = specials[$urandom_range(0, 8)];
            else if (kind == 9)
            begin
                frame.delete();
                repeat ($urandom_range(1, 12)) frame.push_back(octet_t'($urandom_range(0, 255)));
            end

            send_frame();
            sent += frame.size();
            if ($urandom_range(0, 29) == 0)
                drain();
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned line_set[N_SETTINGS];
        int unsigned char_set[N_SETTINGS];
        // Limit settings: smallest, zero, small, largest, over the cap
        line_set = '{1, 0, 3, 1024, 2047, 5};
        char_set = '{1, 0, 6, 1024, 4, 2047};

        sb            = new();
        rst_n         = 1'b0;
        rx.valid      = 1'b0;
        rx.rx_byte    = '0;
        cfg.valid     = 1'b0;
        cfg.reg_index = atrp_pkg::CFG_LINE_LIMIT;
        cfg.wr_data   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening, reset limits:
        //  - response with one line holding the printable extremes, then OK
        //  - CR right after '+': syntax error that restarts at the LF wait
        //    with the counts cleared
        //  - DEL in line text is rejected
        //  - bare CR LF ERROR CR LF response with no '+' lines
        frame = '{atrp_pkg::CH_CR, atrp_pkg::CH_LF, atrp_pkg::CH_PLUS, atrp_pkg::CH_SPACE,
                  atrp_pkg::CH_TILDE, atrp_pkg::CH_CR, atrp_pkg::CH_LF,
                  atrp_pkg::CH_CR, atrp_pkg::CH_LF, atrp_pkg::CH_O, atrp_pkg::CH_K,
                  atrp_pkg::CH_CR, atrp_pkg::CH_LF,
                  atrp_pkg::CH_CR, atrp_pkg::CH_LF, atrp_pkg::CH_PLUS, atrp_pkg::CH_CR,
                  atrp_pkg::CH_LF, atrp_pkg::CH_PLUS, CH_DEL,
                  atrp_pkg::CH_CR, atrp_pkg::CH_LF, atrp_pkg::CH_E, atrp_pkg::CH_R,
                  atrp_pkg::CH_R, atrp_pkg::CH_O, atrp_pkg::CH_R, atrp_pkg::CH_CR,
                  atrp_pkg::CH_LF};
        send_frame();
        run_phase(PHASE_BYTES);

        for (int p = 0; p < N_SETTINGS; p++)
        begin
            // run_phase ends drained, so the block is idle here
            write_reg(atrp_pkg::CFG_LINE_LIMIT, count_t'(line_set[p]));
            write_reg(atrp_pkg::CFG_LENGTH_LIMIT, count_t'(char_set[p]));
            run_phase(PHASE_BYTES);
        end

        drain();
        $display("summary: %0d bytes sent, %0d results checked over %0d limit settings",
                 bytes_sent, sb.checked, N_SETTINGS + 1);
        $display("summary: %0d OK and %0d ERROR responses, %0d syntax errors,",
                 sb.ok_frames, sb.error_frames, sb.syntax_hits);
        $display("         %0d long and %0d extra-line drops",
                 sb.long_drops, sb.many_drops);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/atrp_pkg.sv
rtl/core/atrp_if.sv
rtl/core/atrp_step.sv
rtl/core/at_response_parser.sv
rtl/core/atrp_checker.sv
sim/at_response_parser_test.sv
